### rtl/scm_pkg.sv
`default_nettype none
package scm_pkg;
    localparam int FFT_BINS_DEF = 4096;
    localparam int COLUMNS_DEF  = 1024;
    localparam int MAX_RESULTS  = 16;
    localparam int CFG_W        = 28;
    localparam int IDX_W        = 3;
    localparam int QDEPTH       = 4;
    localparam logic signed [15:0] LOWEST_LEVEL = 16'sh8000;

    localparam logic [IDX_W-1:0] REG_FIRST_BIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_COLUMN_STEP = 3'd1;
    localparam logic [IDX_W-1:0] REG_LEVEL_OFS   = 3'd2;
    localparam logic [IDX_W-1:0] REG_TOP_LEVEL   = 3'd3;
    localparam logic [IDX_W-1:0] REG_Y_SCALE     = 3'd4;
    localparam logic [IDX_W-1:0] REG_LOW_THR     = 3'd5;
    localparam logic [IDX_W-1:0] REG_HIGH_THR    = 3'd6;
    localparam logic [IDX_W-1:0] REG_INV_RANGE   = 3'd7;

    // closed column request from front to back
    typedef struct packed {
        logic [9:0]         column;
        logic signed [16:0] level;
        logic               last;
    } t_col;
endpackage
`default_nettype wire

### rtl/scm_front.sv
`default_nettype none
module scm_front
    import scm_pkg::*;
#(
    parameter int FFT_BINS = FFT_BINS_DEF,
    parameter int COLUMNS  = COLUMNS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic signed [15:0] i_bin_level,
    input  wire logic               i_first_of_frame,
    input  wire logic [11:0]        i_first_bin,
    input  wire logic [27:0]        i_column_step,
    input  wire logic signed [12:0] i_level_offset,
    output logic                    o_col_valid,
    output t_col                    o_col,
    input  wire logic               i_col_ready
);
    localparam int BW = $clog2(FFT_BINS + 1);
    localparam int CW = $clog2(COLUMNS + 1);
    localparam int EW = BW + 16;
    localparam int BURST_W = $clog2(MAX_RESULTS + 1);
    localparam logic [EW-1:0] END_LIM = EW'(FFT_BINS) << 16;

    logic               r_busy, n_busy;
    logic signed [15:0] r_lvl;
    logic               r_pend, n_pend;
    logic [BW-1:0]      r_b;
    logic [BW-1:0]      r_bin_cnt, n_bin_cnt;
    logic [CW-1:0]      r_col, n_col;
    logic signed [15:0] r_peak, n_peak;
    logic [EW-1:0]      r_end, n_end;
    logic [BURST_W-1:0] r_burst, n_burst;

    logic [EW:0]        sum_end;
    logic [EW-1:0]      step_end, start_end;
    logic [BW-1:0]      end_bin;
    logic               line_open, merge_now, close_now;
    logic signed [15:0] merged_peak;

    assign o_full = r_busy;
    assign sum_end  = {1'b0, r_end} + (EW+1)'(i_column_step);
    assign step_end = (sum_end > (EW+1)'(END_LIM)) ? END_LIM : sum_end[EW-1:0];
    always_comb begin
        logic [EW:0] s;
        s = ((EW+1)'(i_first_bin) << 16) + (EW+1)'(i_column_step);
        start_end = (s > (EW+1)'(END_LIM)) ? END_LIM : s[EW-1:0];
    end
    assign end_bin   = r_end[EW-1:16];
    assign line_open = (r_col < CW'(COLUMNS));
    assign merge_now = r_pend && (end_bin > r_b);
    assign merged_peak = (merge_now && (r_lvl > r_peak)) ? r_lvl : r_peak;
    assign close_now = line_open && (r_burst < BURST_W'(MAX_RESULTS)) &&
                       !((BW+1)'(end_bin) > (BW+1)'(r_b) + (BW+1)'(1));

    assign o_col_valid = r_busy && close_now;
    assign o_col.column = r_col[9:0];
    assign o_col.level  = 17'(merged_peak) + 17'(i_level_offset);
    assign o_col.last   = (r_col == CW'(COLUMNS - 1));

    // per item column walk, one column per cycle while the back end is ready
    always_comb begin
        n_busy = r_busy; n_pend = r_pend; n_bin_cnt = r_bin_cnt;
        n_col = r_col; n_peak = r_peak; n_end = r_end; n_burst = r_burst;
        if (!r_busy) begin
            if (i_push) begin
                n_busy = 1'b1;
                n_burst = '0;
                if (i_first_of_frame) begin
                    n_bin_cnt = '0; n_col = '0; n_peak = LOWEST_LEVEL; n_end = start_end;
                end
            end
        end else if (close_now) begin
            if (i_col_ready) begin
                n_pend = r_pend && !merge_now;
                n_col = r_col + CW'(1);
                n_end = step_end;
                n_peak = LOWEST_LEVEL;
                n_burst = r_burst + BURST_W'(1);
            end
        end else begin
            // a bin still pending goes into the oldest open column
            if (line_open && r_pend && (r_lvl > r_peak)) n_peak = r_lvl;
            n_busy = 1'b0;
            if (r_bin_cnt < BW'(FFT_BINS)) n_bin_cnt = r_bin_cnt + BW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_push) begin
            r_lvl <= i_bin_level;
            r_b   <= i_first_of_frame ? '0 : r_bin_cnt;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_pend <= 1'b0; r_bin_cnt <= '0; r_col <= '0;
            r_peak <= LOWEST_LEVEL; r_end <= EW'(16'd4) << 16; r_burst <= '0;
        end else begin
            r_busy <= n_busy; r_bin_cnt <= n_bin_cnt; r_col <= n_col;
            r_peak <= n_peak; r_end <= n_end; r_burst <= n_burst;
            if (!r_busy && i_push) begin
                logic [BW-1:0] bb;
                bb = i_first_of_frame ? '0 : r_bin_cnt;
                r_pend <= (bb >= BW'(i_first_bin)) && (bb < BW'(FFT_BINS));
            end else begin
                r_pend <= n_pend;
            end
        end
    end

`ifndef ASSERT_OFF
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst <= BURST_W'(MAX_RESULTS)) else $error("burst overrun");
    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(COLUMNS)) else $error("column overrun");
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end <= END_LIM) else $error("end beyond buffer");
`endif
endmodule
`default_nettype wire

### rtl/scm_back.sv
`default_nettype none
module scm_back
    import scm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_col_valid,
    input  wire t_col               i_col,
    output logic                    o_col_ready,
    input  wire logic signed [12:0] i_top_level,
    input  wire logic [19:0]        i_y_scale,
    input  wire logic signed [12:0] i_low_threshold,
    input  wire logic signed [12:0] i_high_threshold,
    input  wire logic [23:0]        i_inverse_range,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output logic [9:0]              o_column,
    output logic [9:0]              o_y_position,
    output logic [7:0]              o_red,
    output logic [7:0]              o_green,
    output logic [7:0]              o_blue,
    output logic                    o_last_column
);
    localparam int QW = $clog2(QDEPTH);
    localparam logic [24:0] U = 25'd16777216;

    // stage 1: products
    logic        r_v1;
    t_col        r_c1;
    logic signed [38:0] r_prod;
    logic [1:0]  r_cls;
    logic [42:0] r_p;
    // stage 2: segment and colour
    logic        r_v2;
    t_col        r_c2;
    logic [9:0]  r_y;
    logic [7:0]  r_r, r_g, r_b;

    logic        q_full;
    logic        adv1, adv2;
    logic [QW:0] r_cnt;
    logic [QW-1:0] r_wp, r_rp;
    logic [9:0]  m_col [QDEPTH];
    logic [9:0]  m_y   [QDEPTH];
    logic [7:0]  m_r [QDEPTH], m_g [QDEPTH], m_b [QDEPTH];
    logic        m_l [QDEPTH];

    // room for everything in flight
    assign q_full = (r_cnt + (QW+1)'(r_v1) + (QW+1)'(r_v2)) >= (QW+1)'(QDEPTH);
    assign o_col_ready = !q_full;
    assign adv1 = i_col_valid && o_col_ready;

    // stage 1 products
    always_ff @(posedge i_clk) begin
        logic signed [17:0] d;
        logic [17:0] dl;
        d = 18'(i_top_level) - 18'(i_col.level);
        dl = 18'(i_col.level) - 18'(i_low_threshold);
        r_c1 <= i_col;
        r_prod <= 39'(d) * $signed({1'b0, i_y_scale});
        if (i_col.level < 17'(i_low_threshold)) r_cls <= 2'd0;
        else if (i_col.level > 17'(i_high_threshold)) r_cls <= 2'd1;
        else r_cls <= 2'd2;
        r_p <= 43'(dl) * 43'(i_inverse_range);
        if (!i_rst_n) r_v1 <= 1'b0; else r_v1 <= adv1;
    end

    function automatic logic [7:0] f255(input logic [26:0] num, input logic [1:0] sh);
        logic [34:0] m;
        m = 35'(num) * 35'd255;
        return 8'(m >> (24 + sh));
    endfunction

    // stage 2 y saturation and colour segment
    always_ff @(posedge i_clk) begin
        logic [24:0] p;
        logic [28:0] t;
        logic [22:0] yq;
        p = (r_p > 43'(U)) ? U : r_p[24:0];
        t = 29'(p) * 29'd9;
        yq = 23'(r_prod >>> 16);
        r_c2 <= r_c1;
        if (r_prod < 0) r_y <= '0;
        else if (r_prod[38:16] > 23'd1023) r_y <= 10'd1023;
        else r_y <= yq[9:0];
        r_r <= 8'd0; r_g <= 8'd0; r_b <= 8'd0;
        case (r_cls)
            2'd0: begin end
            2'd1: begin r_r <= 8'd255; r_g <= 8'd255; end
            default: begin
                if (t < 29'(U)*2) r_b <= f255(27'(t), 2'd1);
                else if (t < 29'(U)*3) begin r_g <= f255(27'(t - 29'(U)*2), 2'd0); r_b <= 8'd255; end
                else if (t < 29'(U)*4) begin r_g <= 8'd255; r_b <= f255(27'(29'(U)*4 - t), 2'd0); end
                else if (t < 29'(U)*5) begin r_r <= f255(27'(t - 29'(U)*4), 2'd0); r_g <= 8'd255; end
                else if (t < 29'(U)*7) begin r_r <= 8'd255; r_g <= f255(27'(29'(U)*7 - t), 2'd1); end
                else if (t < 29'(U)*8) begin r_r <= 8'd255; r_b <= f255(27'(t - 29'(U)*7), 2'd0); end
                else begin
                    r_r <= f255(27'(29'(U)*12 - t), 2'd2);
                    r_g <= f255(27'(t - 29'(U)*8), 2'd1);
                    r_b <= 8'd255;
                end
            end
        endcase
        if (!i_rst_n) r_v2 <= 1'b0; else r_v2 <= r_v1;
    end

    // result queue
    assign adv2 = r_v2;
    assign o_empty = (r_cnt == '0);
    always_ff @(posedge i_clk) begin
        if (adv2) begin
            m_col[r_wp] <= r_c2.column; m_y[r_wp] <= r_y; m_r[r_wp] <= r_r;
            m_g[r_wp] <= r_g; m_b[r_wp] <= r_b; m_l[r_wp] <= r_c2.last;
        end
        if (!i_rst_n) begin
            r_cnt <= '0; r_wp <= '0; r_rp <= '0;
        end else begin
            if (adv2) r_wp <= r_wp + QW'(1);
            if (i_pop && !o_empty) r_rp <= r_rp + QW'(1);
            r_cnt <= r_cnt + (QW+1)'(adv2) - (QW+1)'(i_pop && !o_empty);
        end
    end
    assign o_column = m_col[r_rp];
    assign o_y_position = m_y[r_rp];
    assign o_red = m_r[r_rp];
    assign o_green = m_g[r_rp];
    assign o_blue = m_b[r_rp];
    assign o_last_column = m_l[r_rp];

`ifndef ASSERT_OFF
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QW+1)'(QDEPTH)) else $error("queue overflow");
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt + (QW+1)'(r_v1) + (QW+1)'(r_v2)) <= (QW+1)'(QDEPTH)) else $error("no room");
    a_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |=> r_v2) else $error("pipe lost request");
`endif
endmodule
`default_nettype wire

### rtl/spectrum_column_max_color_mapper_top.sv
// Spectrum column peak mapper: one FFT bin per accepted push. The front column
// walker stays busy after each push while it closes columns (up to sixteen),
// one column at a time, and also waits whenever the back end has no room;
// closed columns pass a two-stage multiply and colour pipeline into a
// four-entry result queue, so a slow reader stalls the walker.
`default_nettype none
module spectrum_column_max_color_mapper_top
    import scm_pkg::*;
#(
    parameter int FFT_BINS = FFT_BINS_DEF,
    parameter int COLUMNS  = COLUMNS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] i_bin_level,
    input  wire logic               i_first_of_frame,
    output logic                    empty,
    input  wire logic               pop,
    output logic [9:0]              o_column,
    output logic [9:0]              o_y_position,
    output logic [7:0]              o_red,
    output logic [7:0]              o_green,
    output logic [7:0]              o_blue,
    output logic                    o_last_column,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data
);
    logic [11:0]        r_first_bin;
    logic [27:0]        r_column_step;
    logic signed [12:0] r_level_offset, r_top_level, r_low_thr, r_high_thr;
    logic [19:0]        r_y_scale;
    logic [23:0]        r_inv_range;
    logic               col_valid, col_ready;
    t_col               col;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_bin <= '0; r_column_step <= 28'd262144; r_level_offset <= '0;
            r_top_level <= '0; r_y_scale <= 20'd5825; r_low_thr <= -13'sd2080;
            r_high_thr <= -13'sd1280; r_inv_range <= 24'd20972;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FIRST_BIN:   r_first_bin <= i_cfg_data[11:0];
                REG_COLUMN_STEP: r_column_step <= i_cfg_data[27:0];
                REG_LEVEL_OFS:   r_level_offset <= i_cfg_data[12:0];
                REG_TOP_LEVEL:   r_top_level <= i_cfg_data[12:0];
                REG_Y_SCALE:     r_y_scale <= i_cfg_data[19:0];
                REG_LOW_THR:     r_low_thr <= i_cfg_data[12:0];
                REG_HIGH_THR:    r_high_thr <= i_cfg_data[12:0];
                REG_INV_RANGE:   r_inv_range <= i_cfg_data[23:0];
                default: begin end
            endcase
        end
    end

    scm_front #(.FFT_BINS(FFT_BINS), .COLUMNS(COLUMNS)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_bin_level, .i_first_of_frame,
        .i_first_bin(r_first_bin), .i_column_step(r_column_step),
        .i_level_offset(r_level_offset),
        .o_col_valid(col_valid), .o_col(col), .i_col_ready(col_ready)
    );

    scm_back u_back (
        .i_clk, .i_rst_n, .i_col_valid(col_valid), .i_col(col), .o_col_ready(col_ready),
        .i_top_level(r_top_level), .i_y_scale(r_y_scale),
        .i_low_threshold(r_low_thr), .i_high_threshold(r_high_thr),
        .i_inverse_range(r_inv_range),
        .o_empty(empty), .i_pop(pop),
        .o_column, .o_y_position, .o_red, .o_green, .o_blue, .o_last_column
    );
endmodule
`default_nettype wire

### sim/tb_spectrum_column_max_color_mapper_top.sv
`timescale 1ns / 1ps
module tb_spectrum_column_max_color_mapper_top;
    import scm_pkg::*;

    localparam int   BIN_COUNT   = FFT_BINS_DEF;
    localparam int   COL_COUNT   = COLUMNS_DEF;
    localparam int   STALL_LIMIT = 2000;
    localparam int   HOLD_CYCLES = 300;
    localparam int   DRAIN_WAIT  = 40;
    localparam longint unsigned Q24_ONE = 64'd16777216;

    typedef struct {
        logic signed [15:0] level;
        logic               frame_start;
    } bin_req_t;

    typedef struct {
        logic [9:0] column;
        logic [9:0] y_pos;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic signed [15:0] i_bin_level = '0;
    logic i_first_of_frame = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [9:0] o_column;
    logic [9:0] o_y_position;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;
    logic o_last_column;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    bin_req_t bin_queue[$];
    pixel_t   pixel_queue[$];
    int  errors = 0;
    int  pixels_seen = 0;
    bit  quiet = 1'b0;

    // shadow copy of register file and column walker state
    int unsigned first_bin_r, step_r, y_scale_r, inv_range_r;
    int          offset_r, top_r, low_thr_r, high_thr_r;
    int unsigned bin_cnt, col_cnt;
    int          peak;
    longint unsigned col_end;

    spectrum_column_max_color_mapper_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_bin_level(i_bin_level), .i_first_of_frame(i_first_of_frame),
        .empty(empty), .pop(pop), .o_column(o_column), .o_y_position(o_y_position),
        .o_red(o_red), .o_green(o_green), .o_blue(o_blue),
        .o_last_column(o_last_column), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic void clamp_col_end();
        if (col_end > (longint'(BIN_COUNT) << 16)) col_end = longint'(BIN_COUNT) << 16;
    endfunction

    function automatic void restart_line();
        col_cnt = 0;
        peak = int'(LOWEST_LEVEL);
        col_end = (longint'(first_bin_r) << 16) + step_r;
        clamp_col_end();
    endfunction

    function automatic logic [7:0] scale255(longint unsigned num, longint unsigned den);
        return 8'((64'd255 * num) / den);
    endfunction

    // closes the current column into an expected pixel
    function automatic void close_column();
        pixel_t px;
        int lvl;
        longint prod;
        longint unsigned p, t, n, u;
        lvl = peak + offset_r;
        u = Q24_ONE;
        prod = (longint'(top_r) - longint'(lvl)) * longint'(y_scale_r);
        if (prod < 0) px.y_pos = 0;
        else if ((prod >>> 16) > 1023) px.y_pos = 10'd1023;
        else px.y_pos = 10'(prod >>> 16);
        px.column = 10'(col_cnt);
        px.last = (col_cnt == COL_COUNT - 1);
        if (lvl < low_thr_r) begin
            px.red = 0; px.green = 0; px.blue = 0;
        end else if (lvl > high_thr_r) begin
            px.red = 255; px.green = 255; px.blue = 0;
        end else begin
            p = longint'(lvl - low_thr_r) * longint'(inv_range_r);
            if (p > u) p = u;
            t = 9 * p;
            if (t < 2 * u) begin
                px.red = 0; px.green = 0; px.blue = scale255(t, 2 * u);
            end else if (t < 3 * u) begin
                px.red = 0; px.green = scale255(t - 2 * u, u); px.blue = 255;
            end else if (t < 4 * u) begin
                px.red = 0; px.green = 255; px.blue = scale255(u - (t - 3 * u), u);
            end else if (t < 5 * u) begin
                px.red = scale255(t - 4 * u, u); px.green = 255; px.blue = 0;
            end else if (t < 7 * u) begin
                px.red = 255; px.green = scale255(2 * u - (t - 5 * u), 2 * u); px.blue = 0;
            end else if (t < 8 * u) begin
                px.red = 255; px.green = 0; px.blue = scale255(t - 7 * u, u);
            end else begin
                n = t - 8 * u;
                px.red = scale255(4 * u - n, 4 * u);
                px.green = scale255(n, 2 * u);
                px.blue = 255;
            end
        end
        pixel_queue.push_back(px);
    endfunction

    // walks the columns that one accepted bin closes
    function automatic void predict_bin(logic signed [15:0] level, logic frame_start);
        int lvl;
        int unsigned b;
        bit merge;
        int closed;
        longint unsigned col_stop;
        lvl = level;
        closed = 0;
        if (frame_start) begin
            bin_cnt = 0;
            restart_line();
        end
        b = bin_cnt;
        merge = (b >= first_bin_r) && (b < BIN_COUNT);
        while (col_cnt < COL_COUNT && closed < MAX_RESULTS) begin
            col_stop = col_end >> 16;
            if (merge && col_stop > b) begin
                if (lvl > peak) peak = lvl;
                merge = 0;
            end
            if (col_stop > longint'(b) + 1) break;
            close_column();
            closed++;
            col_cnt++;
            col_end += step_r;
            clamp_col_end();
            peak = int'(LOWEST_LEVEL);
        end
        if (merge && col_cnt < COL_COUNT && lvl > peak) peak = lvl;
        if (bin_cnt < BIN_COUNT) bin_cnt++;
    endfunction

    // bin driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        bin_req_t req;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) predict_bin(i_bin_level, i_first_of_frame);
            if (push && full) begin
                push <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (bin_queue.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 15) - 1;
                push <= 1'b0;
            end else if (bin_queue.size() > 0) begin
                req = bin_queue.pop_front();
                push <= 1'b1;
                i_bin_level <= req.level;
                i_first_of_frame <= req.frame_start;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // pixel monitor with random pop stalls and one long hold-off
    int pop_gap = 0;
    int hold_cnt = 0;
    bit hold_done = 0;
    always @(posedge i_clk) begin
        pixel_t px;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                pixels_seen++;
                if (pixel_queue.size() == 0) begin
                    $error("unexpected pixel for column %0d", o_column);
                    errors++;
                end else begin
                    px = pixel_queue.pop_front();
                    if (o_column !== px.column) begin
                        $error("column: expected %0d got %0d", px.column, o_column);
                        errors++;
                    end
                    if (o_y_position !== px.y_pos) begin
                        $error("y_position: expected %0d got %0d", px.y_pos, o_y_position);
                        errors++;
                    end
                    if (o_red !== px.red) begin
                        $error("red: expected %0d got %0d", px.red, o_red);
                        errors++;
                    end
                    if (o_green !== px.green) begin
                        $error("green: expected %0d got %0d", px.green, o_green);
                        errors++;
                    end
                    if (o_blue !== px.blue) begin
                        $error("blue: expected %0d got %0d", px.blue, o_blue);
                        errors++;
                    end
                    if (o_last_column !== px.last) begin
                        $error("last_column: expected %0d got %0d", px.last, o_last_column);
                        errors++;
                    end
                end
            end
            if (!hold_done && pixels_seen >= 20) begin
                hold_done = 1;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop_gap = $urandom_range(1, 15) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted request
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_spectrum_column_max_color_mapper_top: FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_W'(value);
        case (idx)
            REG_FIRST_BIN:   first_bin_r = value & 32'hFFF;
            REG_COLUMN_STEP: step_r = value & 32'hFFFFFFF;
            REG_LEVEL_OFS:   offset_r = int'(signed'(13'(value)));
            REG_TOP_LEVEL:   top_r = int'(signed'(13'(value)));
            REG_Y_SCALE:     y_scale_r = value & 32'hFFFFF;
            REG_LOW_THR:     low_thr_r = int'(signed'(13'(value)));
            REG_HIGH_THR:    high_thr_r = int'(signed'(13'(value)));
            REG_INV_RANGE:   inv_range_r = value & 32'hFFFFFF;
            default: ;
        endcase
    endtask

    task automatic write_done();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_bin(int level, bit frame_start);
        bin_req_t req;
        req.level = 16'(level);
        req.frame_start = frame_start;
        bin_queue.push_back(req);
    endtask

    // wait for the walker and result pipeline to empty out
    task automatic settle();
        while (bin_queue.size() > 0 || push || pixel_queue.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // half the levels near the colour thresholds, half anywhere
    function automatic int pick_level();
        if ($urandom_range(0, 1)) return int'(signed'(16'($urandom())));
        return $urandom_range(0, high_thr_r - low_thr_r + 400) + low_thr_r - 200 - offset_r;
    endfunction

    initial begin
        int frames;
        int len;
        first_bin_r = 0; step_r = 262144; offset_r = 0; top_r = 0;
        y_scale_r = 5825; low_thr_r = -2080; high_thr_r = -1280; inv_range_r = 20972;
        bin_cnt = 0;
        restart_line();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, level extremes
        add_bin(-32768, 1); add_bin(32767, 0); add_bin(0, 0); add_bin(-1, 0);
        add_bin(-2080, 0); add_bin(-1280, 0); add_bin(-1700, 0); add_bin(-32768, 0);
        settle();

        // bins before the window, empty columns, equal thresholds, large scale
        write_reg(REG_FIRST_BIN, 2);
        write_reg(REG_COLUMN_STEP, 4096);
        write_reg(REG_LEVEL_OFS, 4095);
        write_reg(REG_TOP_LEVEL, -4096);
        write_reg(REG_Y_SCALE, 1048575);
        write_reg(REG_LOW_THR, -100);
        write_reg(REG_HIGH_THR, -100);
        write_reg(REG_INV_RANGE, 16777215);
        write_done();
        add_bin(100, 1); add_bin(-4195, 0); add_bin(-4195, 0); add_bin(-4196, 0);
        add_bin(32767, 0); add_bin(-32768, 0);
        settle();

        // opposite extremes
        write_reg(REG_LEVEL_OFS, -4096);
        write_reg(REG_TOP_LEVEL, 4095);
        write_reg(REG_Y_SCALE, 0);
        write_reg(REG_LOW_THR, -4096);
        write_reg(REG_HIGH_THR, 4095);
        write_reg(REG_INV_RANGE, 0);
        write_reg(REG_COLUMN_STEP, 70000);
        write_done();
        add_bin(5, 1); add_bin(4000, 0); add_bin(-30000, 0); add_bin(12345, 0);
        add_bin(-7, 1); add_bin(32767, 0);
        settle();

        // random frames under random settings
        for (int phase = 0; phase < 5; phase++) begin
            write_reg(REG_FIRST_BIN, $urandom_range(0, 8));
            write_reg(REG_COLUMN_STEP, $urandom_range(4096, 200000));
            write_reg(REG_LEVEL_OFS, $urandom_range(0, 400) - 200);
            write_reg(REG_TOP_LEVEL, $urandom_range(0, 8191) - 4096);
            write_reg(REG_Y_SCALE, $urandom_range(0, 1048575));
            low_thr_r = $urandom_range(0, 3000) - 3000;
            write_reg(REG_LOW_THR, low_thr_r);
            write_reg(REG_HIGH_THR, low_thr_r + $urandom_range(1, 1500));
            write_reg(REG_INV_RANGE, 16777216 / (high_thr_r - low_thr_r));
            write_done();
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                len = $urandom_range(4, 14);
                add_bin(pick_level(), 1);
                for (int k = 0; k < len; k++) add_bin(pick_level(), $urandom_range(0, 19) == 0);
            end
            settle();
        end

        // narrowest columns so every bin hits the burst limit, no idling
        quiet = 1'b1;
        write_reg(REG_FIRST_BIN, 0);
        write_reg(REG_COLUMN_STEP, 4096);
        write_reg(REG_LEVEL_OFS, 0);
        write_reg(REG_Y_SCALE, 5825);
        write_done();
        add_bin(pick_level(), 1);
        for (int k = 1; k < 12; k++) add_bin(pick_level(), 0);
        settle();

        if (errors == 0) begin
            $display("tb_spectrum_column_max_color_mapper_top: PASS");
        end else begin
            $display("tb_spectrum_column_max_color_mapper_top: FAIL");
        end
        $finish;
    end
endmodule
